// File: sv/pcyl_pkg.sv
`timescale 1ns / 1ps

package pcyl_pkg;

    // Number formats
    localparam int COORD_W  = 20;               // signed Q12.8 coordinate
    localparam int AXIS_FB  = 14;               // axis fraction bits
    localparam int AXIS_CW  = AXIS_FB + 2;      // signed Q1.AXIS_FB component
    localparam int LEN_W    = 19;               // unsigned Q11.8 length / radius

    // Derived datapath widths
    localparam int AXIS_PK_W = 3 * AXIS_CW;
    localparam int ORIG_PK_W = 3 * COORD_W;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = DIFF_W + AXIS_CW;
    localparam int PROJ_W    = PROD_W + 2;
    localparam int MAG_W     = PROJ_W;
    localparam int R_W       = LEN_W + AXIS_FB;
    localparam int H_W       = LEN_W + AXIS_FB - 1;
    localparam int HR_W      = R_W + 1;
    localparam int CMP_W     = (MAG_W > HR_W) ? MAG_W : HR_W;
    localparam int SQ_LO_W   = (CMP_W + 1) / 2;
    localparam int SQ_HI_W   = CMP_W - SQ_LO_W;
    localparam int SQ_W      = 2 * CMP_W;
    localparam int RSQ_W     = 2 * R_W;
    localparam int RAD_W     = SQ_W + 1;
    localparam int G2_W      = RAD_W + 1;

    // Configuration port
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 6;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_AXIS_U = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_V = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_W = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LENGTH = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd6;

    // Pipeline stages
    localparam int NSTAGE   = 8;
    localparam int STG_DIFF = 0;
    localparam int STG_PROD = 1;
    localparam int STG_PROJ = 2;
    localparam int STG_PREP = 3;
    localparam int STG_SQ   = 4;
    localparam int STG_RAD  = 5;
    localparam int STG_CMP  = 6;
    localparam int STG_OUT  = 7;

    typedef logic [NSTAGE-1:0]    stage_en_t;
    typedef logic [AXIS_PK_W-1:0] axis_t;
    typedef logic [ORIG_PK_W-1:0] origin_t;
    typedef logic [MAG_W-1:0]     mag_t;
    typedef logic [CMP_W-1:0]     sq_in_t;
    typedef logic [SQ_W-1:0]      sq_t;
    typedef logic [H_W-1:0]       half_len_t;
    typedef logic [R_W-1:0]       radius_q_t;
    typedef logic [RSQ_W-1:0]     rsq_t;

    typedef struct packed {
        logic ge_h;     // |pw| >= length/2
        logic gt_h;     // |pw| >  length/2
        logic ge_hr;    // |pw| >= length/2 + radius
    } axial_flags_t;

    localparam axis_t AXIS_U_RST = axis_t'(1) << AXIS_FB;
    localparam axis_t AXIS_V_RST = axis_t'(1) << (AXIS_CW + AXIS_FB);
    localparam axis_t AXIS_W_RST = axis_t'(1) << (2 * AXIS_CW + AXIS_FB);

endpackage

// File: sv/point_in_oriented_cylinder_test.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// --------  ---------  ----------------------  ----------------------------------
// in        request    in_valid / in_ready     point_x, point_y, point_z (Q12.8)
// out       result     out_valid / out_ready   inside_res
// cfg       APB write  psel, penable, pwrite   paddr, pwdata; prdata read back
//
// One point enters per cycle while out_ready does not hold the pipeline. The
// 8 pipeline stages are difference, axis products, projection sums, axial
// tests and square partials, squares, radial sum, radius compares, final
// decision.
// rst_n clears the valid bits and loads the default solid; no clearing pass.
// Each stage holds while it is full and the stage after it holds, so bubbles
// close up and a stall at the output drops and repeats nothing.
module point_in_oriented_cylinder_test (
    input  logic                                clk,
    input  logic                                rst_n,
    // point requests
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [pcyl_pkg::COORD_W-1:0] point_x,
    input  logic signed [pcyl_pkg::COORD_W-1:0] point_y,
    input  logic signed [pcyl_pkg::COORD_W-1:0] point_z,
    // results
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                inside_res,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pcyl_pkg::ADDR_W-1:0]         paddr,
    input  logic [pcyl_pkg::DATA_W-1:0]         pwdata,
    output logic [pcyl_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import pcyl_pkg::*;

    // Configuration registers
    axis_t              axis_u_reg;
    axis_t              axis_v_reg;
    axis_t              axis_w_reg;
    origin_t            origin_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [LEN_W-1:0]   radius_reg;
    logic               mode_reg;
    rsq_t               r_sq_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    // Pipeline control
    stage_en_t          en;
    stage_en_t          valid_reg;
    stage_en_t          valid_next;

    mag_t               mag_u;
    mag_t               mag_v;
    mag_t               mag_w;
    half_len_t          half_len;
    radius_q_t          radius_q;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_u_reg <= AXIS_U_RST;
            axis_v_reg <= AXIS_V_RST;
            axis_w_reg <= AXIS_W_RST;
            origin_reg <= '0;
            length_reg <= '0;
            radius_reg <= '0;
            mode_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_AXIS_U: axis_u_reg <= pwdata[AXIS_PK_W-1:0];
                REG_AXIS_V: axis_v_reg <= pwdata[AXIS_PK_W-1:0];
                REG_AXIS_W: axis_w_reg <= pwdata[AXIS_PK_W-1:0];
                REG_ORIGIN: origin_reg <= pwdata[ORIG_PK_W-1:0];
                REG_LENGTH: length_reg <= pwdata[LEN_W-1:0];
                REG_RADIUS: radius_reg <= pwdata[LEN_W-1:0];
                REG_MODE:   mode_reg   <= pwdata[0];
                default:    ;   // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_AXIS_U: prdata = DATA_W'(axis_u_reg);
            REG_AXIS_V: prdata = DATA_W'(axis_v_reg);
            REG_AXIS_W: prdata = DATA_W'(axis_w_reg);
            REG_ORIGIN: prdata = DATA_W'(origin_reg);
            REG_LENGTH: prdata = DATA_W'(length_reg);
            REG_RADIUS: prdata = DATA_W'(radius_reg);
            REG_MODE:   prdata = DATA_W'(mode_reg);
            default:    prdata = '0;
        endcase
    end

    // Radius and half length aligned to the projection's fraction bits;
    // the squared radius is refreshed every cycle from the radius register.
    assign radius_q = {radius_reg, AXIS_FB'(0)};
    assign half_len = {length_reg, (AXIS_FB-1)'(0)};

    always_ff @(posedge clk)
    begin
        r_sq_reg <= rsq_t'((2*LEN_W)'(radius_reg) * (2*LEN_W)'(radius_reg)) << (2 * AXIS_FB);
    end

    // Advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NSTAGE; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NSTAGE-1];

    // Stages 0 to 2: offset from origin and projection onto the three axes
    pcyl_project u_project (
        .clk     (clk),
        .en      (en),
        .point_x (point_x),
        .point_y (point_y),
        .point_z (point_z),
        .origin  (origin_reg),
        .axis_u  (axis_u_reg),
        .axis_v  (axis_v_reg),
        .axis_w  (axis_w_reg),
        .mag_u   (mag_u),
        .mag_v   (mag_v),
        .mag_w   (mag_w)
    );

    // Stages 3 to 7: squares, radial and end-cap compares, final answer
    pcyl_decide u_decide (
        .clk          (clk),
        .en           (en),
        .mag_u        (mag_u),
        .mag_v        (mag_v),
        .mag_w        (mag_w),
        .half_len     (half_len),
        .radius_q     (radius_q),
        .r_sq         (r_sq_reg),
        .capsule_mode (mode_reg),
        .is_inside    (inside_res)
    );

endmodule

// File: sv/pcyl_project.sv
`timescale 1ns / 1ps

module pcyl_project (
    input  logic                                clk,
    input  pcyl_pkg::stage_en_t                 en,
    input  logic signed [pcyl_pkg::COORD_W-1:0] point_x,
    input  logic signed [pcyl_pkg::COORD_W-1:0] point_y,
    input  logic signed [pcyl_pkg::COORD_W-1:0] point_z,
    input  pcyl_pkg::origin_t                   origin,
    input  pcyl_pkg::axis_t                     axis_u,
    input  pcyl_pkg::axis_t                     axis_v,
    input  pcyl_pkg::axis_t                     axis_w,
    output pcyl_pkg::mag_t                      mag_u,
    output pcyl_pkg::mag_t                      mag_v,
    output pcyl_pkg::mag_t                      mag_w
);
    import pcyl_pkg::*;

    logic signed [COORD_W-1:0] pt      [3];
    logic signed [COORD_W-1:0] org     [3];
    axis_t                     ax      [3];
    logic signed [AXIS_CW-1:0] comp    [3][3];
    logic signed [DIFF_W-1:0]  diff_next [3];
    logic signed [DIFF_W-1:0]  diff_reg  [3];
    logic signed [PROD_W-1:0]  prod_next [3][3];
    logic signed [PROD_W-1:0]  prod_reg  [3][3];
    logic [PROJ_W-1:0]         proj_sum  [3];
    mag_t                      mag_next  [3];
    mag_t                      mag_reg   [3];

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;
    assign ax[0] = axis_u;
    assign ax[1] = axis_v;
    assign ax[2] = axis_w;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            org[k]       = origin[k*COORD_W +: COORD_W];
            diff_next[k] = {pt[k][COORD_W-1], pt[k]} - {org[k][COORD_W-1], org[k]};
        end
        for (int a = 0; a < 3; a++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                comp[a][k]      = ax[a][k*AXIS_CW +: AXIS_CW];
                prod_next[a][k] = PROD_W'(diff_reg[k]) * PROD_W'(comp[a][k]);
            end
        end
        // sum three products, then take the magnitude
        for (int a = 0; a < 3; a++)
        begin
            proj_sum[a] = PROJ_W'(prod_reg[a][0]) + PROJ_W'(prod_reg[a][1])
                        + PROJ_W'(prod_reg[a][2]);
            mag_next[a] = proj_sum[a][PROJ_W-1] ? mag_t'(~proj_sum[a] + 1'b1)
                                                : mag_t'(proj_sum[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_DIFF])
        begin
            diff_reg <= diff_next;
        end
        if (en[STG_PROD])
        begin
            prod_reg <= prod_next;
        end
        if (en[STG_PROJ])
        begin
            mag_reg <= mag_next;
        end
    end

    assign mag_u = mag_reg[0];
    assign mag_v = mag_reg[1];
    assign mag_w = mag_reg[2];

endmodule

// File: sv/pcyl_square.sv
`timescale 1ns / 1ps

// Two-stage squarer: split the operand into halves, form three partial
// products, then add them.
module pcyl_square (
    input  logic             clk,
    input  logic             en_mul,
    input  logic             en_sum,
    input  pcyl_pkg::sq_in_t a,
    output pcyl_pkg::sq_t    sq
);
    import pcyl_pkg::*;

    logic [SQ_HI_W-1:0]         a_hi;
    logic [SQ_LO_W-1:0]         a_lo;
    logic [2*SQ_HI_W-1:0]       hh_reg;
    logic [SQ_HI_W+SQ_LO_W-1:0] hl_reg;
    logic [2*SQ_LO_W-1:0]       ll_reg;
    sq_t                        sq_next;
    sq_t                        sq_reg;

    assign a_hi = a[CMP_W-1:SQ_LO_W];
    assign a_lo = a[SQ_LO_W-1:0];

    assign sq_next = (sq_t'(hh_reg) << (2 * SQ_LO_W))
                   + (sq_t'(hl_reg) << (SQ_LO_W + 1))
                   + sq_t'(ll_reg);

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            hh_reg <= (2*SQ_HI_W)'(a_hi) * (2*SQ_HI_W)'(a_hi);
            hl_reg <= (SQ_HI_W+SQ_LO_W)'(a_hi) * (SQ_HI_W+SQ_LO_W)'(a_lo);
            ll_reg <= (2*SQ_LO_W)'(a_lo) * (2*SQ_LO_W)'(a_lo);
        end
        if (en_sum)
        begin
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

// File: sv/pcyl_decide.sv
`timescale 1ns / 1ps

module pcyl_decide (
    input  logic                  clk,
    input  pcyl_pkg::stage_en_t   en,
    input  pcyl_pkg::mag_t        mag_u,
    input  pcyl_pkg::mag_t        mag_v,
    input  pcyl_pkg::mag_t        mag_w,
    input  pcyl_pkg::half_len_t   half_len,
    input  pcyl_pkg::radius_q_t   radius_q,
    input  pcyl_pkg::rsq_t        r_sq,
    input  logic                  capsule_mode,
    output logic                  is_inside
);
    import pcyl_pkg::*;

    logic [CMP_W-1:0] aw_c;
    logic [CMP_W-1:0] h_c;
    logic [CMP_W-1:0] hr_c;
    axial_flags_t     flags_next;
    axial_flags_t     flags3_reg;
    axial_flags_t     flags4_reg;
    axial_flags_t     flags5_reg;
    axial_flags_t     flags6_reg;
    sq_in_t           f_next;
    sq_in_t           f_reg;
    sq_t              sq_u;
    sq_t              sq_v;
    sq_t              sq_f;
    logic [RAD_W-1:0] radial_reg;
    logic             rad_ge_reg;
    logic [G2_W-1:0]  g2_reg;
    logic             g2_ge;
    logic             inside_next;
    logic             inside_reg;

    // Axial tests; the end-cap excess only matters when it lies below the radius
    always_comb
    begin
        aw_c             = CMP_W'(mag_w);
        h_c              = CMP_W'(half_len);
        hr_c             = CMP_W'(half_len) + CMP_W'(radius_q);
        flags_next.ge_h  = (aw_c >= h_c);
        flags_next.gt_h  = (aw_c >  h_c);
        flags_next.ge_hr = (aw_c >= hr_c);
        f_next           = aw_c - h_c;
    end

    pcyl_square u_sq_u (
        .clk    (clk),
        .en_mul (en[STG_PREP]),
        .en_sum (en[STG_SQ]),
        .a      (sq_in_t'(mag_u)),
        .sq     (sq_u)
    );

    pcyl_square u_sq_v (
        .clk    (clk),
        .en_mul (en[STG_PREP]),
        .en_sum (en[STG_SQ]),
        .a      (sq_in_t'(mag_v)),
        .sq     (sq_v)
    );

    pcyl_square u_sq_f (
        .clk    (clk),
        .en_mul (en[STG_SQ]),
        .en_sum (en[STG_RAD]),
        .a      (f_reg),
        .sq     (sq_f)
    );

    assign g2_ge = (g2_reg >= G2_W'(r_sq));

    always_comb
    begin
        if (rad_ge_reg)
        begin
            inside_next = 1'b0;
        end
        else if (capsule_mode)
        begin
            if (flags6_reg.ge_hr)
            begin
                inside_next = 1'b0;
            end
            else if (!flags6_reg.gt_h)
            begin
                inside_next = 1'b1;
            end
            else
            begin
                inside_next = !g2_ge;
            end
        end
        else
        begin
            inside_next = !flags6_reg.ge_h;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_PREP])
        begin
            flags3_reg <= flags_next;
            f_reg      <= f_next;
        end
        if (en[STG_SQ])
        begin
            flags4_reg <= flags3_reg;
        end
        if (en[STG_RAD])
        begin
            flags5_reg <= flags4_reg;
            radial_reg <= RAD_W'(sq_u) + RAD_W'(sq_v);
        end
        if (en[STG_CMP])
        begin
            flags6_reg <= flags5_reg;
            rad_ge_reg <= (radial_reg >= RAD_W'(r_sq));
            g2_reg     <= G2_W'(radial_reg) + G2_W'(sq_f);
        end
        if (en[STG_OUT])
        begin
            inside_reg <= inside_next;
        end
    end

    assign is_inside = inside_reg;

endmodule

// File: tb/sv/tb_point_in_oriented_cylinder_test.sv
`timescale 1ns / 1ps

module tb_point_in_oriented_cylinder_test;

    import pcyl_pkg::*;

    // Exact signed arithmetic: squared projections need under 80 bits
    typedef logic signed [127:0] acc_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef struct {
        coord_t px;
        coord_t py;
        coord_t pz;
        logic   verdict;
    } inside_expect_t;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;   // decodes to no register
    localparam int AXIS_ONE        = 1 << AXIS_FB;
    localparam int PIPE_SLACK      = NSTAGE + 4;
    localparam int ITEMS_PER_SOLID = 63;
    localparam int SOLID_ROUNDS    = 6;
    localparam int CYCLE_LIMIT     = 200000;

    // Tracks the configured solid and predicts inside_res for every point request
    class inside_checker;
        axis_t   axis_u;
        axis_t   axis_v;
        axis_t   axis_w;
        origin_t origin;
        len_t    length;
        len_t    radius;
        logic    capsule;
        inside_expect_t expected_inside[$];
        int      mismatches;

        function new();
            axis_u     = AXIS_U_RST;
            axis_v     = AXIS_V_RST;
            axis_w     = AXIS_W_RST;
            origin     = '0;
            length     = '0;
            radius     = '0;
            capsule    = 1'b0;
            mismatches = 0;
        endfunction

        // Mirror a register write; bits above the register width drop out
        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_AXIS_U: axis_u  = value[AXIS_PK_W-1:0];
                REG_AXIS_V: axis_v  = value[AXIS_PK_W-1:0];
                REG_AXIS_W: axis_w  = value[AXIS_PK_W-1:0];
                REG_ORIGIN: origin  = value[ORIG_PK_W-1:0];
                REG_LENGTH: length  = value[LEN_W-1:0];
                REG_RADIUS: radius  = value[LEN_W-1:0];
                REG_MODE:   capsule = value[0];
                default: ;
            endcase
        endfunction

        function acc_t project(axis_t a, acc_t dx, acc_t dy, acc_t dz);
            return acc_t'($signed(a[0 +: AXIS_CW])) * dx
                 + acc_t'($signed(a[AXIS_CW +: AXIS_CW])) * dy
                 + acc_t'($signed(a[2*AXIS_CW +: AXIS_CW])) * dz;
        endfunction

        function logic point_is_inside(coord_t px, coord_t py, coord_t pz);
            acc_t dx, dy, dz, pu, pv, pw, aw, rq, hq, r2, radial, f;
            logic in_solid;
            dx = acc_t'(px) - acc_t'($signed(origin[0 +: COORD_W]));
            dy = acc_t'(py) - acc_t'($signed(origin[COORD_W +: COORD_W]));
            dz = acc_t'(pz) - acc_t'($signed(origin[2*COORD_W +: COORD_W]));
            pu = project(axis_u, dx, dy, dz);
            pv = project(axis_v, dx, dy, dz);
            pw = project(axis_w, dx, dy, dz);
            aw = (pw < 0) ? -pw : pw;
            // Bring radius and half length to the projection's fraction bits
            rq = acc_t'(radius) <<< AXIS_FB;
            hq = acc_t'(length) <<< (AXIS_FB - 1);
            r2 = rq * rq;
            radial = pu * pu + pv * pv;
            if (radial >= r2) begin
                in_solid = 1'b0;
            end
            else if (capsule) begin
                if (aw >= hq + rq) begin
                    in_solid = 1'b0;
                end
                else begin
                    // Past the flat part, test against the end sphere
                    f = aw - hq;
                    in_solid = (f <= 0) || (radial + f * f < r2);
                end
            end
            else begin
                in_solid = (aw < hq);
            end
            return in_solid;
        endfunction

        function void note_point(coord_t px, coord_t py, coord_t pz);
            inside_expect_t e;
            e.px = px;
            e.py = py;
            e.pz = pz;
            e.verdict = point_is_inside(px, py, pz);
            expected_inside.push_back(e);
        endfunction

        function void check_inside(logic got);
            inside_expect_t e;
            if (expected_inside.size() == 0) begin
                if (mismatches < 10)
                    $display("[%0t] inside_res=%b arrived with no point pending", $realtime, got);
                mismatches++;
            end
            else begin
                e = expected_inside.pop_front();
                if (got !== e.verdict) begin
                    if (mismatches < 10)
                        $display("[%0t] point (%0d,%0d,%0d): inside_res expected %b, got %b",
                                 $realtime, e.px, e.py, e.pz, e.verdict, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    coord_t               point_x;
    coord_t               point_y;
    coord_t               point_z;
    logic                 out_valid;
    logic                 out_ready;
    logic                 inside_res;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    inside_checker board;
    bit            bursts_on = 1'b1;    // random idling on both sides
    int            ready_hold = 0;
    int            cycles = 0;

    point_in_oriented_cylinder_test i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .inside_res (inside_res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Hard stop in case the pipeline hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side backpressure: drop out_ready in random bursts
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready  <= 1'b0;
        end
        else if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            ready_hold <= $urandom_range(0, 9);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Sample both handshakes on the edge that completes them.
    // Check the result first: it always belongs to an older request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_inside(inside_res);
            if (in_valid && in_ready)
                board.note_point(point_x, point_y, point_z);
        end
    end

    // Issue one point request; optionally idle first, then hold until taken
    task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x  <= x;
        point_y  <= y;
        point_z  <= z;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Setup cycle, then access cycle; the register loads when pready is high.
    // Idle afterwards so the next write starts on a fresh edge.
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending, wait out every pending result, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        while (board.expected_inside.size() != 0)
            @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    // Write all registers; fill the unused upper data bits with noise
    task automatic load_solid(input axis_t u, input axis_t v, input axis_t w,
                              input origin_t o, input len_t len, input len_t rad,
                              input logic cap);
        apb_write(REG_AXIS_U, {16'($urandom), u});
        apb_write(REG_AXIS_V, {16'($urandom), v});
        apb_write(REG_AXIS_W, {16'($urandom), w});
        apb_write(REG_ORIGIN, {4'($urandom), o});
        apb_write(REG_LENGTH, {32'($urandom), 13'($urandom), len});
        apb_write(REG_RADIUS, {32'($urandom), 13'($urandom), rad});
        apb_write(REG_MODE,   {$urandom, 31'($urandom), cap});
    endtask

    function automatic axis_t axis_row(int pos, int comp);
        axis_t r;
        r = '0;
        r[pos*AXIS_CW +: AXIS_CW] = AXIS_CW'(comp);
        return r;
    endfunction

    function automatic coord_t near_coord(logic [COORD_W-1:0] centre, int span);
        int off;
        off = int'($urandom_range(0, 2 * span)) - span;
        return COORD_W'($signed(centre) + off);
    endfunction

    function automatic int rand_sign(int mag);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    initial
    begin
        int      round;
        int      n;
        int      kind;
        int      p0;
        int      p1;
        int      s;
        int      span;
        axis_t   u;
        axis_t   v;
        axis_t   w;
        origin_t o;
        len_t    len;
        len_t    rad;
        coord_t  px;
        coord_t  py;
        coord_t  pz;

        board    = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        point_x  = '0;
        point_y  = '0;
        point_z  = '0;
        out_ready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default solid has zero radius: every point must come back outside
        send_point(0, 0, 0);
        send_point(524287, 524287, 524287);
        send_point(-524288, -524288, -524288);
        drain();

        // Flat cylinder on the identity frame: length 10.0, radius 2.0.
        // A write to the unused address must leave the solid alone.
        load_solid(AXIS_U_RST, AXIS_V_RST, AXIS_W_RST, '0, 19'd2560, 19'd512, 1'b0);
        apb_write(REG_UNUSED, {$urandom, $urandom});
        send_point(0, 0, 0);
        send_point(511, 0, 0);
        send_point(512, 0, 0);          // radial distance equal to radius
        send_point(0, 0, 1279);
        send_point(0, 0, 1280);         // axial distance equal to half length
        send_point(0, 0, -1280);
        send_point(-511, 0, -1279);
        send_point(362, 362, 0);
        send_point(524287, -524288, 524287);
        drain();

        // Capsule, radius 5/4 of a 3-4-5 triangle to hit the end sphere exactly
        load_solid(AXIS_U_RST, AXIS_V_RST, AXIS_W_RST, '0, 19'd2560, 19'd500, 1'b1);
        send_point(0, 0, 1280);         // at the end of the flat part
        send_point(0, 0, 1779);
        send_point(0, 0, -1780);        // reaches half length plus radius
        send_point(300, 0, 1680);       // on the end sphere
        send_point(299, 0, 1680);
        send_point(0, -300, -1680);
        send_point(499, 0, 0);
        drain();

        // Extreme registers: unnormalized full-scale axes, origin at the range
        // limits, largest length and radius
        u = {16'h0000, 16'h8000, 16'h7FFF};
        v = {16'h8000, 16'h7FFF, 16'h0000};
        w = {16'h7FFF, 16'h0000, 16'h8000};
        o = {20'h00000, 20'h7FFFF, 20'h80000};
        load_solid(u, v, w, o, 19'h7FFFF, 19'h7FFFF, 1'b1);
        send_point(-524288, 524287, 0);
        send_point(524287, -524288, -524288);
        send_point(0, 0, 524287);
        send_point(1000, -1000, 1000);
        drain();

        // Random solids, most points scattered around the solid
        for (round = 0; round < SOLID_ROUNDS; round++)
        begin
            kind = round % 3;
            if (kind == 0)
            begin
                // Signed permutation of the unit frame
                p0 = $urandom_range(0, 2);
                p1 = (p0 + 1 + $urandom_range(0, 1)) % 3;
                u = axis_row(p0, rand_sign(AXIS_ONE));
                v = axis_row(p1, rand_sign(AXIS_ONE));
                w = axis_row(3 - p0 - p1, rand_sign(AXIS_ONE));
            end
            else if (kind == 1)
            begin
                // Near-rotation about z from a 3-4-5 triangle
                s = rand_sign(13107);
                u = axis_row(0, 9830) | axis_row(1, s);
                v = axis_row(0, -s) | axis_row(1, 9830);
                w = axis_row(2, rand_sign(AXIS_ONE));
            end
            else
            begin
                u = axis_t'({$urandom, $urandom});
                v = axis_t'({$urandom, $urandom});
                w = axis_t'({$urandom, $urandom});
            end

            if (round == SOLID_ROUNDS - 1)
                o = origin_t'({$urandom, $urandom});
            else
                o = {COORD_W'(int'($urandom_range(0, 400000)) - 200000),
                     COORD_W'(int'($urandom_range(0, 400000)) - 200000),
                     COORD_W'(int'($urandom_range(0, 400000)) - 200000)};
            len = LEN_W'($urandom_range(0, 8192));
            rad = LEN_W'($urandom_range(1, 4096));
            load_solid(u, v, w, o, len, rad, round[0]);

            // No idling at all in the last round
            if (round == SOLID_ROUNDS - 1)
                bursts_on = 1'b0;

            span = (int'(len) / 2 + int'(rad)) * 5 / 4 + 16;
            for (n = 0; n < ITEMS_PER_SOLID; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    px = COORD_W'($urandom);
                    py = COORD_W'($urandom);
                    pz = COORD_W'($urandom);
                end
                else
                begin
                    px = near_coord(o[0 +: COORD_W], span);
                    py = near_coord(o[COORD_W +: COORD_W], span);
                    pz = near_coord(o[2*COORD_W +: COORD_W], span);
                end
                send_point(px, py, pz);
            end
            drain();
        end

        if (board.mismatches == 0 && board.expected_inside.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: point_in_oriented_cylinder_test.f
sv/pcyl_pkg.sv
sv/pcyl_project.sv
sv/pcyl_square.sv
sv/pcyl_decide.sv
sv/point_in_oriented_cylinder_test.sv
tb/sv/tb_point_in_oriented_cylinder_test.sv
